// File: sv/gbfb_pkg.sv
// Package for the glyph blit frame buffer.
// Holds display and font sizes, the font ROM, payload and control types and a helper function.
// Has no dependencies; every other file of the block imports it.
package gbfb_pkg;

  localparam int DISPLAY_ROWS = 8;
  localparam int DISPLAY_COLS = 60;
  localparam int GLYPH_ROWS   = 5;
  localparam int GLYPH_COLS   = 7;

  localparam int FONT_GLYPHS = 5;
  localparam int FONT_ROWS   = 5;
  localparam int FONT_COLS   = 7;
  localparam int ROM_DEPTH   = FONT_GLYPHS * FONT_ROWS;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);

  // Glyph rows past the stored font are never drawn; glyph columns past it are off.
  localparam int DRAW_ROWS = (GLYPH_ROWS < FONT_ROWS) ? GLYPH_ROWS : FONT_ROWS;
  localparam int MASK_COLS = (GLYPH_COLS < FONT_COLS) ? GLYPH_COLS : FONT_COLS;

  localparam int ROW_W     = $clog2(DISPLAY_ROWS);
  localparam int COL_W     = $clog2(DISPLAY_COLS);
  localparam int PIXEL_W   = 60;
  localparam int ROW_NUM_W = 3;

  typedef logic [DISPLAY_COLS-1:0] word_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [FONT_COLS-1:0]    pattern_t;

  // Font patterns, five rows per glyph, bit j is glyph column j. The last glyph is blank.
  localparam pattern_t GLYPH_ROM [ROM_DEPTH] = '{
    7'h1C, 7'h22, 7'h3E, 7'h22, 7'h22,
    7'h1E, 7'h22, 7'h3E, 7'h22, 7'h1E,
    7'h3C, 7'h02, 7'h02, 7'h02, 7'h3C,
    7'h1E, 7'h22, 7'h22, 7'h22, 7'h1E,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_DRAW   = 2'd1,
    ACT_RENDER = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_RENDER
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [2:0] glyph_index;
    logic [7:0] start_row;
    logic [7:0] start_col;
  } cmd_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]   row_pixels;
    logic [ROW_NUM_W-1:0] row_number;
    logic                 last_row;
  } pix_t;

  // Requests from the sequencer to the row store.
  typedef struct packed {
    logic  clear;
    logic  rd_en;
    row_t  rd_addr;
    logic  wr_en;
    row_t  wr_addr;
    word_t wr_data;
  } rs_req_t;

  // Remainder of an 8-bit value by a constant divisor. Each multiple of the divisor is
  // compared against the value on its own, and the largest one that fits is subtracted.
  function automatic logic [7:0] wrap_u8(input logic [7:0] v, input int d);
    logic [7:0] r;
    r = v;
    for (int k = 1; k <= 255; k++) begin
      if (k * d <= 255 && v >= 8'(k * d)) begin
        r = v - 8'(k * d);
      end
    end
    return r;
  endfunction

endpackage

// File: sv/gbfb_row_store.sv
// Row store of the glyph blit frame buffer: one synchronous memory word per display row.
// Per-row valid bits make never-written or cleared rows read as all off.
// Depends on gbfb_pkg.
module gbfb_row_store (
  input  logic             clk,
  input  logic             rst,
  input  gbfb_pkg::rs_req_t req,
  output gbfb_pkg::word_t  rd_data
);
  import gbfb_pkg::*;

  word_t                   mem [DISPLAY_ROWS];
  logic [DISPLAY_ROWS-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= vld[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.clear) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

endmodule

// File: sv/gbfb_glyph_mask.sv
// Glyph row to frame row mask: places one font row at a wrapped column position.
// Pure combinational logic; depends on gbfb_pkg.
module gbfb_glyph_mask (
  input  gbfb_pkg::pattern_t pattern,
  input  gbfb_pkg::col_t     col_base,
  output gbfb_pkg::word_t    mask
);
  import gbfb_pkg::*;

  always_comb begin
    logic [COL_W:0] col;
    mask = '0;
    col  = '0;
    for (int j = 0; j < MASK_COLS; j++) begin
      // The base is already below the width, so one subtraction wraps the column.
      col = {1'b0, col_base} + (COL_W+1)'(j);
      if (col >= (COL_W+1)'(DISPLAY_COLS)) begin
        col = col - (COL_W+1)'(DISPLAY_COLS);
      end
      if (pattern[j]) begin
        mask[col[COL_W-1:0]] = 1'b1;
      end
    end
  end

endmodule

// File: sv/glyph_blit_frame_buffer.sv
// Top level of the glyph blit frame buffer: command sequencer, read-modify-write pipeline
// and row output register. Depends on gbfb_pkg, gbfb_row_store and gbfb_glyph_mask.
//
//   channel | handshake             | payload        | transaction
//   --------+-----------------------+----------------+---------------------------------
//   command | cmd_valid, cmd_ready  | cmd   (cmd_t)  | clear, draw glyph or render
//   pixels  | pix_valid, pix_ready  | pix   (pix_t)  | one display row of a render
//
// A clear drops all row valid bits at once. A draw reads and rewrites one row per cycle for
// five rows. A render reads the eight rows one per cycle while the pixel side does not stall;
// the row store has a single read port. Reset is synchronous and leaves every pixel off. When
// the pixel side stalls, reads stop and the row in the read register is held until the output
// register frees up; no row is lost or repeated.
module glyph_blit_frame_buffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  gbfb_pkg::cmd_t cmd,
  output logic           pix_valid,
  input  logic           pix_ready,
  output gbfb_pkg::pix_t pix
);
  import gbfb_pkg::*;

  // Sequencer state. The counter walks glyph rows during a draw and display rows during a render.
  state_t state, state_next;
  row_t   cnt, cnt_next;
  row_t   row_ptr, row_ptr_next;
  logic [2:0] glyph;
  col_t   col_base;

  // Stage one: the row whose read data sits in the row store's read register.
  logic  s1_valid;
  logic  s1_draw;
  row_t  s1_addr;
  word_t s1_mask;
  logic  s1_last;

  // The previous write, kept for forwarding into a read of the same row.
  logic  wr_prev_valid;
  row_t  wr_prev_addr;
  word_t wr_prev_data;

  rs_req_t req;
  word_t   rd_data;
  word_t   base_word;
  word_t   issue_mask;
  pattern_t pattern;
  logic [ROM_AW-1:0] rom_addr;

  logic cmd_take;
  logic pix_free;
  logic s1_free;
  logic issue;
  logic issue_last;

  assign cmd_take = cmd_valid && cmd_ready;
  assign pix_free = !pix_valid || pix_ready;
  // A draw entry never waits to retire; a render entry waits for the output register.
  assign s1_free  = !s1_valid || s1_draw || pix_free;

  // Font row for the glyph row being issued.
  assign rom_addr = ROM_AW'(glyph) * ROM_AW'(FONT_ROWS) + ROM_AW'(cnt);
  assign pattern  = GLYPH_ROM[rom_addr];

  gbfb_glyph_mask u_mask (
    .pattern  (pattern),
    .col_base (col_base),
    .mask     (issue_mask)
  );

  gbfb_row_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // The read that lands in stage one may have missed a write of the same row in the same cycle.
  assign base_word = (wr_prev_valid && wr_prev_addr == s1_addr) ? wr_prev_data : rd_data;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    row_ptr_next = row_ptr;
    cmd_ready    = 1'b0;
    issue        = 1'b0;
    issue_last   = 1'b0;
    req.clear    = 1'b0;
    req.rd_en    = 1'b0;
    req.rd_addr  = row_ptr;
    req.wr_en    = s1_valid && s1_draw;
    req.wr_addr  = s1_addr;
    req.wr_data  = base_word | s1_mask;

    case (state)
      ST_IDLE: begin
        cmd_ready = !s1_valid;
        if (cmd_take) begin
          case (cmd.action)
            ACT_CLEAR: begin
              req.clear = 1'b1;
            end
            ACT_DRAW: begin
              // Glyph numbers past the font draw nothing.
              if (cmd.glyph_index < 3'(FONT_GLYPHS)) begin
                state_next   = ST_DRAW;
                cnt_next     = '0;
                row_ptr_next = ROW_W'(wrap_u8(cmd.start_row, DISPLAY_ROWS));
              end
            end
            ACT_RENDER: begin
              state_next = ST_RENDER;
              cnt_next   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        issue       = 1'b1;
        req.rd_en   = 1'b1;
        req.rd_addr = row_ptr;
        cnt_next    = cnt + 1'b1;
        row_ptr_next = (row_ptr == ROW_W'(DISPLAY_ROWS - 1)) ? '0 : row_ptr + 1'b1;
        if (cnt == ROW_W'(DRAW_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_RENDER: begin
        req.rd_addr = cnt;
        if (s1_free) begin
          issue      = 1'b1;
          req.rd_en  = 1'b1;
          cnt_next   = cnt + 1'b1;
          issue_last = (cnt == ROW_W'(DISPLAY_ROWS - 1));
          if (issue_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    row_ptr <= row_ptr_next;
    if (cmd_take) begin
      glyph    <= cmd.glyph_index;
      col_base <= COL_W'(wrap_u8(cmd.start_col, DISPLAY_COLS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_draw       <= 1'b0;
      wr_prev_valid <= 1'b0;
    end else begin
      wr_prev_valid <= req.wr_en;
      if (issue) begin
        s1_valid <= 1'b1;
        s1_draw  <= (state == ST_DRAW);
      end else if (s1_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr <= req.rd_addr;
      s1_mask <= (state == ST_DRAW) ? issue_mask : '0;
      s1_last <= issue_last;
    end
    wr_prev_addr <= req.wr_addr;
    wr_prev_data <= req.wr_data;
  end

  // Output register: takes a rendered row from stage one whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s1_valid && !s1_draw && pix_free) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_draw && pix_free) begin
      pix.row_pixels <= PIXEL_W'(rd_data);
      pix.row_number <= ROW_NUM_W'(s1_addr);
      pix.last_row   <= s1_last;
    end
  end

  // A command is only taken once the read-modify-write pipeline has drained.
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !s1_valid)
    else $error("command taken while stage one is busy");

  // The flagged row of a render is always the bottom display row.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix.last_row) |-> pix.row_number == ROW_NUM_W'(DISPLAY_ROWS - 1))
    else $error("last row flag on a row other than the bottom one");

  // Issuing the bottom row ends the render sequence.
  a_render_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RENDER && issue_last) |=> state == ST_IDLE && s1_valid && s1_last)
    else $error("render did not finish after the bottom row");

  // Writes come only from draw entries, never while a render is reading.
  a_no_write_render: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> state != ST_RENDER)
    else $error("row write during a render");

endmodule

// File: tb/tb_glyph_blit_frame_buffer.sv
// Self-checking testbench for the glyph blit frame buffer: clear, draw and render commands
// go in, rendered rows come out and are compared against an in-bench model of the pixel store.
// Depends on gbfb_pkg and glyph_blit_frame_buffer.
module tb_glyph_blit_frame_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfb_pkg::*;

  // Action code 3 is left unused by the block; it must be swallowed without effect.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Cycles with no transaction on either channel before the run is declared hung. The slowest
  // legitimate quiet spell is the long receiver hold below, plus a render's eight rows each
  // waiting out a random receiver stall, so this is many times over.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic pix_valid;
  logic pix_ready = 1'b0;
  pix_t pix;

  glyph_blit_frame_buffer DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to be offered, and rows that renders have promised but not yet delivered.
  cmd_t pending_cmds[$];
  pix_t expected_rows[$];

  // Shadow copy of the frame buffer, updated in command acceptance order.
  logic [DISPLAY_COLS-1:0] frame_img [DISPLAY_ROWS];

  bit idle_on = 1'b1;    // random idle bursts on both channels
  bit hold_phase = 1'b0; // asks the receiver for its one long hold-off
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_count = 0;
  int stall_cycles = 0;

  // Apply one accepted command to the shadow buffer; a render queues one expected row per
  // display row. Draws OR the glyph in, wrapping both the row and the column.
  task automatic apply_command(input cmd_t c);
    int row;
    int col;
    pix_t exp_row;
    case (c.action)
      ACT_CLEAR: begin
        foreach (frame_img[r]) frame_img[r] = '0;
      end
      ACT_DRAW: begin
        // Glyph numbers past the font draw nothing at all.
        if (c.glyph_index < FONT_GLYPHS) begin
          for (int i = 0; i < GLYPH_ROWS && i < FONT_ROWS; i++) begin
            row = (int'(c.start_row) + i) % DISPLAY_ROWS;
            for (int j = 0; j < GLYPH_COLS && j < FONT_COLS; j++) begin
              if (GLYPH_ROM[c.glyph_index * FONT_ROWS + i][j]) begin
                col = (int'(c.start_col) + j) % DISPLAY_COLS;
                frame_img[row][col] = 1'b1;
              end
            end
          end
        end
      end
      ACT_RENDER: begin
        for (int r = 0; r < DISPLAY_ROWS; r++) begin
          exp_row.row_pixels = frame_img[r];
          exp_row.row_number = 3'(r);
          exp_row.last_row   = (r == DISPLAY_ROWS - 1);
          expected_rows.push_back(exp_row);
        end
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t make_cmd(input logic [1:0] act, input int glyph, input int srow,
                                    input int scol);
    cmd_t c;
    c.action      = action_t'(act);
    c.glyph_index = 3'(glyph);
    c.start_row   = 8'(srow);
    c.start_col   = 8'(scol);
    return c;
  endfunction

  // Mostly draws and renders so the picture builds up between readouts; clears and the
  // spare action are rare, and glyph numbers past the font turn up now and then.
  function automatic cmd_t random_command();
    cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      c.action = ACT_CLEAR;
    end else if (pick < 60) begin
      c.action = ACT_DRAW;
    end else if (pick < 94) begin
      c.action = ACT_RENDER;
    end else begin
      c.action = action_t'(ACT_SPARE);
    end
    c.glyph_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
    c.start_row = 8'($urandom);
    c.start_col = 8'($urandom);
    return c;
  endfunction

  // Command driver. A transaction completes on an edge with valid and ready both high; the
  // model is updated right there, and the next command (or an idle burst) is set up.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        apply_command(cmd);
      end
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          send_gap  = send_gap - 1;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 && idle_on && $urandom_range(0, 4) == 0) begin
          send_gap  = $urandom_range(0, 4);
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd       <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor. Each delivered row is checked against the oldest expected row, field by
  // field. Ready is also throttled here: random bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      pix_ready <= 1'b0;
    end else begin
      if (pix_valid && pix_ready) begin
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected row: pixels=%h row=%0d last=%0b", $realtime,
                     pix.row_pixels, pix.row_number, pix.last_row);
          end
        end else begin
          pix_t exp_row;
          exp_row = expected_rows.pop_front();
          if (pix.row_pixels !== exp_row.row_pixels || pix.row_number !== exp_row.row_number ||
              pix.last_row !== exp_row.last_row) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: row mismatch: expected pixels=%h row=%0d last=%0b", $realtime,
                       exp_row.row_pixels, exp_row.row_number, exp_row.last_row);
              $display("%0t:                 actual pixels=%h row=%0d last=%0b", $realtime,
                       pix.row_pixels, pix.row_number, pix.last_row);
            end
          end
        end
      end

      if (hold_phase && hold_count < HOLD_CYCLES) begin
        hold_count++;
        pix_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pix_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        pix_ready <= 1'b0;
      end else begin
        pix_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a long run of cycles without a single transaction means the block is hung.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (pix_valid && pix_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("** glyph_blit_frame_buffer: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sequencer. Queue changes happen on the falling edge so the driver sees them cleanly.
  initial begin
    foreach (frame_img[r]) frame_img[r] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: render of the reset picture, glyphs at the corners so both axes wrap,
    // a start position of 255 on both axes, the blank glyph, glyph numbers past the font,
    // the spare action, overlapping draws that must OR together, and a clear.
    pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 1, 255, 255));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 2, 7, 59));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 3, 3, 56));
    pending_cmds.push_back(make_cmd(ACT_RENDER, 7, 255, 255));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 4, 128, 128));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 5, 1, 1));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 7, 2, 30));
    pending_cmds.push_back(make_cmd(ACT_SPARE, 1, 170, 85));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 0, 4, 85));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 3, 5, 86));
    pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_CLEAR, 7, 255, 255));
    pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 6, 170, 85));
    pending_cmds.push_back(make_cmd(ACT_DRAW, 2, 85, 170));
    pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));

    // The sender pauses here until every expected row has come back.
    while (pending_cmds.size() != 0 || cmd_valid || expected_rows.size() != 0) @(negedge clk);

    // Back-to-back renders against a receiver that holds off for a long stretch, so the
    // block backs up and has to stall its command input.
    hold_phase = 1'b1;
    pending_cmds.push_back(make_cmd(ACT_DRAW, 1, 6, 20));
    repeat (5) pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));
    while (hold_count < HOLD_CYCLES || pending_cmds.size() != 0 || cmd_valid ||
           expected_rows.size() != 0) @(negedge clk);
    hold_phase = 1'b0;

    // Random traffic with idle bursts on both sides.
    repeat (55) pending_cmds.push_back(random_command());
    while (pending_cmds.size() != 0) @(negedge clk);

    // Final stretch at full rate with no idling, ending in a render of what is left.
    idle_on = 1'b0;
    repeat (25) pending_cmds.push_back(random_command());
    pending_cmds.push_back(make_cmd(ACT_RENDER, 0, 0, 0));
    while (pending_cmds.size() != 0 || cmd_valid || expected_rows.size() != 0) @(negedge clk);

    // Let any stray output surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += expected_rows.size();
    if (mismatches == 0) begin
      $display("** glyph_blit_frame_buffer: PASSED **");
    end else begin
      $display("** glyph_blit_frame_buffer: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
sv/gbfb_pkg.sv
sv/gbfb_row_store.sv
sv/gbfb_glyph_mask.sv
sv/glyph_blit_frame_buffer.sv
tb/tb_glyph_blit_frame_buffer.sv
